// ----- hw/rtl/hnvt_pkg.sv -----
// ----------------------------------------------------------------------------
// hnvt_pkg
// Shared types, status codes and helpers for the header name/value table.
// ----------------------------------------------------------------------------
package hnvt_pkg;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic PART_NAME  = 1'b0;
	localparam logic PART_VALUE = 1'b1;

	// One result item
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_byte;
		logic       byte_present;
		logic       last;
		logic [4:0] entries_in_use;
	} out_item_t;

	// Fold ASCII upper case onto lower case
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/hnvt_out_reg.sv -----
// ----------------------------------------------------------------------------
// hnvt_out_reg
// Output holding register: keeps one result until the sink takes it.
// ----------------------------------------------------------------------------
module hnvt_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hnvt_pkg::out_item_t item,
	output logic              free,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // out_byte[7:0], entries_in_use[12:8], zero fill
	output logic [2:0]        m_axis_tuser,  // status[1:0], byte_present[2]
	output logic              m_axis_tlast
);
	import hnvt_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	assign free = !valid_q || m_axis_tready;

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			item_q <= item;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, item_q.entries_in_use, item_q.out_byte};
	assign m_axis_tuser  = {item_q.byte_present, item_q.status};
	assign m_axis_tlast  = item_q.last;

endmodule

// ----- hw/rtl/header_name_value_table_core.sv -----
// ----------------------------------------------------------------------------
// header_name_value_table_core
// Table of name/value pairs with case-folded name lookup, set and get.
// ----------------------------------------------------------------------------
// A request end walks the table with one byte compare unit, each name byte
// read (RDN) then compared (CMPN) for entries of equal length. A set copies
// a new entry's name and the value, each byte read then written; a get sends
// value bytes via RDV and OUTV, held while the output is busy. Input is not
// ready during a walk. Reset clears count, stored and pending lengths at once.
module header_name_value_table_core #(
	parameter int MAX_ENTRIES   = 16,
	parameter int MAX_NAME_LEN  = 32,
	parameter int MAX_VALUE_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
	input  logic [2:0]  s_axis_tuser,   // operation[0], part[1], has_byte[2]
	input  logic        s_axis_tlast,   // last_of_part
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // out_byte[7:0], entries_in_use[12:8]
	output logic [2:0]  m_axis_tuser,   // status[1:0], byte_present[2]
	output logic        m_axis_tlast
);
	import hnvt_pkg::*;

	localparam int LMAX = (MAX_NAME_LEN > MAX_VALUE_LEN) ? MAX_NAME_LEN : MAX_VALUE_LEN;
	localparam int NIW  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
	localparam int VIW  = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;
	localparam int EIW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PLW  = $clog2(MAX_NAME_LEN + 1);
	localparam int VLW  = $clog2(MAX_VALUE_LEN + 2);
	localparam int SVW  = $clog2(MAX_VALUE_LEN + 1);
	localparam int ECW  = $clog2(MAX_ENTRIES + 1);
	localparam int KCW  = $clog2(LMAX + 1);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_START  = 12'b000000000010,
		ST_LEN    = 12'b000000000100,
		ST_RDN    = 12'b000000001000,
		ST_CMPN   = 12'b000000010000,
		ST_CPN_RD = 12'b000000100000,
		ST_CPN_WR = 12'b000001000000,
		ST_CPV_RD = 12'b000010000000,
		ST_CPV_WR = 12'b000100000000,
		ST_RDV    = 12'b001000000000,
		ST_OUTV   = 12'b010000000000,
		ST_FIN    = 12'b100000000000
	} state_t;

	state_t           state_q;
	logic             op_q;
	logic             new_q;
	logic             overlong_q;
	logic [PLW-1:0]   plen_q;
	logic [VLW-1:0]   vlen_q;
	logic [ECW-1:0]   cnt_q;
	logic [ECW-1:0]   e_q;
	logic [KCW-1:0]   k_q;
	logic [1:0]       st_q;
	logic [PLW-1:0]   nlen_q [MAX_ENTRIES];
	logic [SVW-1:0]   vlens_q [MAX_ENTRIES];

	// Byte memories
	logic [7:0] pname_mem [MAX_NAME_LEN];
	logic [7:0] pval_mem  [MAX_VALUE_LEN];
	logic [7:0] sname_mem [MAX_ENTRIES][MAX_NAME_LEN];
	logic [7:0] sval_mem  [MAX_ENTRIES][MAX_VALUE_LEN];
	logic [7:0] pn_rd_q, pv_rd_q, sn_rd_q, sv_rd_q;

	logic           in_fire;
	logic           in_op, in_part, in_has;
	logic [EIW-1:0] ei;
	logic [SVW-1:0] cur_vlen;
	logic           out_free;
	logic           out_load;
	out_item_t      out_item;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_op         = s_axis_tuser[0];
	assign in_part       = s_axis_tuser[1];
	assign in_has        = s_axis_tuser[2];
	assign ei            = e_q[EIW-1:0];
	assign cur_vlen      = vlens_q[ei];

	// Pending buffers: written by incoming bytes
	always_ff @(posedge clk) begin
		if (in_fire && in_has && in_part == PART_NAME && plen_q < PLW'(MAX_NAME_LEN)) begin
			pname_mem[plen_q[NIW-1:0]] <= s_axis_tdata;
		end
		if (in_fire && in_has && in_part == PART_VALUE && in_op == OP_SET &&
				vlen_q < VLW'(MAX_VALUE_LEN)) begin
			pval_mem[vlen_q[VIW-1:0]] <= s_axis_tdata;
		end
		pn_rd_q <= pname_mem[k_q[NIW-1:0]];
		pv_rd_q <= pval_mem[k_q[VIW-1:0]];
	end

	// Table memories: written by the copy loops
	always_ff @(posedge clk) begin
		if (state_q == ST_CPN_WR) begin
			sname_mem[ei][k_q[NIW-1:0]] <= pn_rd_q;
		end
		if (state_q == ST_CPV_WR) begin
			sval_mem[ei][k_q[VIW-1:0]] <= pv_rd_q;
		end
		sn_rd_q <= sname_mem[ei][k_q[NIW-1:0]];
		sv_rd_q <= sval_mem[ei][k_q[VIW-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_SET;
			new_q      <= 1'b0;
			overlong_q <= 1'b0;
			plen_q     <= '0;
			vlen_q     <= '0;
			cnt_q      <= '0;
			e_q        <= '0;
			k_q        <= '0;
			st_q       <= STATUS_OK;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				nlen_q[i]  <= '0;
				vlens_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_part == PART_NAME) begin
							if (in_has) begin
								if (plen_q < PLW'(MAX_NAME_LEN)) begin
									plen_q <= plen_q + 1'b1;
								end else begin
									overlong_q <= 1'b1;
								end
							end
							if (s_axis_tlast && in_op == OP_GET) begin
								op_q    <= OP_GET;
								state_q <= ST_START;
							end
						end else if (in_op == OP_SET) begin
							if (in_has) begin
								if (vlen_q < VLW'(MAX_VALUE_LEN)) begin
									vlen_q <= vlen_q + 1'b1;
								end else begin
									vlen_q <= VLW'(MAX_VALUE_LEN + 1);
								end
							end
							if (s_axis_tlast) begin
								op_q    <= OP_SET;
								state_q <= ST_START;
							end
						end
					end
				end
				ST_START: begin
					e_q <= '0;
					k_q <= '0;
					if (overlong_q || (op_q == OP_SET && vlen_q > VLW'(MAX_VALUE_LEN))) begin
						st_q    <= STATUS_TOO_LONG;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					k_q <= '0;
					if (e_q == cnt_q) begin
						// no entry matched
						if (op_q == OP_GET) begin
							st_q    <= STATUS_NOT_FOUND;
							state_q <= ST_FIN;
						end else if (cnt_q == ECW'(MAX_ENTRIES)) begin
							st_q    <= STATUS_FULL;
							state_q <= ST_FIN;
						end else begin
							new_q   <= 1'b1;
							state_q <= ST_CPN_RD;
						end
					end else if (nlen_q[ei] == plen_q) begin
						if (plen_q == '0) begin
							new_q <= 1'b0;
							if (op_q == OP_GET) begin
								st_q    <= STATUS_OK;
								state_q <= (cur_vlen == '0) ? ST_FIN : ST_RDV;
							end else begin
								state_q <= ST_CPV_RD;
							end
						end else begin
							state_q <= ST_RDN;
						end
					end else begin
						e_q <= e_q + 1'b1;
					end
				end
				ST_RDN: begin
					state_q <= ST_CMPN;
				end
				ST_CMPN: begin
					if (fold_byte(sn_rd_q) != fold_byte(pn_rd_q)) begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_LEN;
					end else if (KCW'(k_q + 1'b1) == KCW'(plen_q)) begin
						k_q   <= '0;
						new_q <= 1'b0;
						if (op_q == OP_GET) begin
							st_q    <= STATUS_OK;
							state_q <= (cur_vlen == '0) ? ST_FIN : ST_RDV;
						end else begin
							state_q <= ST_CPV_RD;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RDN;
					end
				end
				ST_CPN_RD: begin
					if (k_q == KCW'(plen_q)) begin
						k_q     <= '0;
						state_q <= ST_CPV_RD;
					end else begin
						state_q <= ST_CPN_WR;
					end
				end
				ST_CPN_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_CPN_RD;
				end
				ST_CPV_RD: begin
					if (k_q == KCW'(vlen_q)) begin
						// commit lengths and count
						vlens_q[ei] <= SVW'(vlen_q);
						if (new_q) begin
							nlen_q[ei] <= plen_q;
							cnt_q      <= cnt_q + 1'b1;
						end
						st_q    <= STATUS_OK;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_CPV_WR;
					end
				end
				ST_CPV_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_CPV_RD;
				end
				ST_RDV: begin
					state_q <= ST_OUTV;
				end
				ST_OUTV: begin
					if (out_free) begin
						if (KCW'(k_q + 1'b1) == KCW'(cur_vlen)) begin
							plen_q     <= '0;
							vlen_q     <= '0;
							overlong_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RDV;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						plen_q     <= '0;
						vlen_q     <= '0;
						overlong_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Build the result item
	always_comb begin
		out_load                = out_free && (state_q == ST_FIN || state_q == ST_OUTV);
		out_item.entries_in_use = 5'(cnt_q);
		if (state_q == ST_OUTV) begin
			out_item.status       = STATUS_OK;
			out_item.out_byte     = sv_rd_q;
			out_item.byte_present = 1'b1;
			out_item.last         = (KCW'(k_q + 1'b1) == KCW'(cur_vlen));
		end else begin
			out_item.status       = st_q;
			out_item.out_byte     = 8'h00;
			out_item.byte_present = 1'b0;
			out_item.last         = 1'b1;
		end
	end

	hnvt_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.item          (out_item),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ECW'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_plen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= PLW'(MAX_NAME_LEN))
		else $error("pending name length above limit");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1 && $past(state_q) == ST_CPV_RD))
		else $error("entry count changed outside commit");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEN |-> e_q <= cnt_q)
		else $error("search ran past used entries");

endmodule
